@@ hdl/kti_pkg.sv @@
// Shared types and codes for the keyframe track interpolator.
package kti_pkg;

    // One keyframe as held in the track table
    typedef struct packed {
        logic [31:0] out_tan;
        logic [31:0] in_tan;
        logic [31:0] value;
        logic [31:0] key_time;
    } t_key;

    // Multiplier operation codes
    localparam logic [2:0] MOP_LIN = 3'd0;
    localparam logic [2:0] MOP_U2  = 3'd1;
    localparam logic [2:0] MOP_U3  = 3'd2;
    localparam logic [2:0] MOP_H00 = 3'd3;
    localparam logic [2:0] MOP_H01 = 3'd4;
    localparam logic [2:0] MOP_H10 = 3'd5;
    localparam logic [2:0] MOP_H11 = 3'd6;

    // Item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register byte addresses
    localparam logic [2:0] ADDR_MODE  = 3'd0;
    localparam logic [2:0] ADDR_COUNT = 3'd4;

    // Interpolation modes
    localparam logic MODE_LINEAR  = 1'b0;
    localparam logic MODE_HERMITE = 1'b1;

    typedef struct packed {
        logic       wr_en;
        logic       load_t;
        logic       scan_start;
        logic       scan_run;
        logic       div_start;
        logic       div_run;
        logic       mul_en;
        logic [2:0] mul_op;
        logic       h_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/kti_ctrl.sv @@
// Sequencer for key writes, bracket search, division and multiply steps.
module kti_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_command,
    input  logic          i_mode,
    input  kti_pkg::t_sts i_sts,
    output logic          o_s_ready,
    output kti_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DINIT = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_LIN   = 4'd4;
    localparam logic [3:0] S_U2    = 4'd5;
    localparam logic [3:0] S_U2W   = 4'd6;
    localparam logic [3:0] S_U3    = 4'd7;
    localparam logic [3:0] S_U3W   = 4'd8;
    localparam logic [3:0] S_HCALC = 4'd9;
    localparam logic [3:0] S_P00   = 4'd10;
    localparam logic [3:0] S_P01   = 4'd11;
    localparam logic [3:0] S_P10   = 4'd12;
    localparam logic [3:0] S_P11   = 4'd13;
    localparam logic [3:0] S_FLUSH = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        o_cmd.mul_op = kti_pkg::MOP_LIN;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_command == kti_pkg::CMD_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load_t     = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_DINIT;
                end else if (i_sts.scan_miss) begin
                    n_state = S_DONE;
                end
            end
            S_DINIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = (i_mode == kti_pkg::MODE_HERMITE) ? S_U2 : S_LIN;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            S_LIN: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_LIN;
                n_state      = S_FLUSH;
            end
            S_U2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_U2;
                n_state      = S_U2W;
            end
            S_U2W: n_state = S_U3;
            S_U3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_U3;
                n_state      = S_U3W;
            end
            S_U3W: n_state = S_HCALC;
            S_HCALC: begin
                o_cmd.h_load = 1'b1;
                n_state      = S_P00;
            end
            S_P00: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_H00;
                n_state      = S_P01;
            end
            S_P01: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_H01;
                n_state      = S_P10;
            end
            S_P10: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_H10;
                n_state      = S_P11;
            end
            S_P11: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kti_pkg::MOP_H11;
                n_state      = S_FLUSH;
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hdl/kti_dp.sv @@
// Track table, bracket search, weight divider, shared multiplier and output register.
module kti_dp #(
    parameter int KEYS      = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kti_pkg::t_cmd i_cmd,
    input  logic [5:0]    i_key_index,
    input  kti_pkg::t_key i_key,
    input  logic [31:0]   i_sample_time,
    input  logic          i_mode,
    input  logic [6:0]    i_key_count,
    input  logic          i_m_ready,
    output kti_pkg::t_sts o_sts,
    output logic          o_m_valid,
    output logic [31:0]   o_sample_value,
    output logic          o_found
);

    localparam int AW   = $clog2(KEYS);
    localparam int IXW  = ((AW > 6) ? AW : 6) + 1;
    localparam int KCW  = ((AW + 1) > 7) ? (AW + 1) : 7;
    localparam int DCW  = $clog2(FRAC_BITS + 1);
    localparam int BW   = FRAC_BITS + 4;
    localparam int PW   = 33 + BW;

    // track table
    kti_pkg::t_key r_mem [KEYS];
    kti_pkg::t_key r_rd;
    kti_pkg::t_key r_prev;
    kti_pkg::t_key r_from;
    kti_pkg::t_key r_to;

    logic [IXW-1:0] wr_idx;
    logic           wr_ok;
    logic [KCW-1:0] cnt_ext;
    logic [KCW-1:0] n_eff;
    logic           last;
    logic           hit;

    logic [AW-1:0]  r_addr;
    logic           r_issue;
    logic           r_rd_vld;
    logic           r_rd_last;
    logic           r_have_prev;
    logic           r_none;
    logic           r_found;
    logic [31:0]    r_t;

    assign wr_idx  = IXW'(i_key_index);
    assign wr_ok   = wr_idx < IXW'(KEYS);
    assign cnt_ext = KCW'(i_key_count);
    assign n_eff   = (cnt_ext > KCW'(KEYS)) ? KCW'(KEYS) : cnt_ext;
    assign last    = (KCW'(r_addr) + KCW'(1)) == n_eff;
    assign hit     = i_cmd.scan_run && r_rd_vld && r_have_prev
                     && (r_prev.key_time < r_t) && (r_rd.key_time > r_t);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            r_mem[wr_idx[AW-1:0]] <= i_key;
        end
        if (i_cmd.scan_run && r_issue) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_have_prev <= 1'b0;
            r_none      <= 1'b0;
            r_found     <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issue     <= n_eff >= KCW'(2);
            r_none      <= n_eff < KCW'(2);
            r_rd_vld    <= 1'b0;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_rd_vld <= r_issue;
            if (r_issue) begin
                r_issue <= !last;
            end
            if (r_rd_vld) begin
                r_have_prev <= 1'b1;
            end
            if (hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_t) begin
            r_t <= i_sample_time;
        end
        if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (i_cmd.scan_run) begin
            if (r_issue) begin
                r_addr    <= r_addr + AW'(1);
                r_rd_last <= last;
            end
            if (r_rd_vld) begin
                r_prev <= r_rd;
            end
            if (hit) begin
                r_from <= r_prev;
                r_to   <= r_rd;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    logic [31:0]          r_rem;
    logic [31:0]          r_dvs;
    logic [FRAC_BITS-1:0] r_u;
    logic [DCW-1:0]       r_dcnt;
    logic [32:0]          rem2;
    logic                 ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCW'(FRAC_BITS);
        end else if (i_cmd.div_run) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= r_t - r_from.key_time;
            r_dvs <= r_to.key_time - r_from.key_time;
        end else if (i_cmd.div_run) begin
            r_rem <= ge ? 32'(rem2 - {1'b0, r_dvs}) : rem2[31:0];
            r_u   <= {r_u[FRAC_BITS-2:0], ge};
        end
    end

    // shared multiplier with one register after it
    logic signed [32:0]   p1;
    logic signed [32:0]   p2;
    logic signed [32:0]   mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] r_prod;
    logic                 r_pvld;
    logic [2:0]           r_pop;
    logic [FRAC_BITS-1:0] r_u2;
    logic [FRAC_BITS-1:0] r_u3;
    logic signed [BW-1:0] r_h00;
    logic signed [BW-1:0] r_h01;
    logic signed [BW-1:0] r_h10;
    logic signed [BW-1:0] r_h11;
    logic signed [BW-1:0] ue;
    logic signed [BW-1:0] u2e;
    logic signed [BW-1:0] u3e;
    logic signed [BW-1:0] one;
    logic signed [63:0]   r_acc;
    logic signed [63:0]   prod_ext;
    logic signed [63:0]   sh;
    logic [31:0]          sat;

    assign p1  = $signed({r_from.value[31], r_from.value});
    assign p2  = $signed({r_to.value[31], r_to.value});
    assign ue  = $signed({4'b0, r_u});
    assign u2e = $signed({4'b0, r_u2});
    assign u3e = $signed({4'b0, r_u3});
    assign one = $signed(BW'(1) << FRAC_BITS);

    always_comb begin
        case (i_cmd.mul_op)
            kti_pkg::MOP_LIN: begin
                mul_a = p2 - p1;
                mul_b = ue;
            end
            kti_pkg::MOP_U2: begin
                mul_a = $signed(33'(r_u));
                mul_b = ue;
            end
            kti_pkg::MOP_U3: begin
                mul_a = $signed(33'(r_u2));
                mul_b = ue;
            end
            kti_pkg::MOP_H00: begin
                mul_a = p1;
                mul_b = r_h00;
            end
            kti_pkg::MOP_H01: begin
                mul_a = p2;
                mul_b = r_h01;
            end
            kti_pkg::MOP_H10: begin
                mul_a = $signed({r_from.in_tan[31], r_from.in_tan});
                mul_b = r_h10;
            end
            kti_pkg::MOP_H11: begin
                mul_a = $signed({r_from.out_tan[31], r_from.out_tan});
                mul_b = r_h11;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = $signed({{(64 - PW){r_prod[PW-1]}}, r_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PW'(mul_a * mul_b);
            r_pop  <= i_cmd.mul_op;
        end
        if (i_cmd.h_load) begin
            r_h00 <= (u3e <<< 1) - (u2e + (u2e <<< 1)) + one;
            r_h01 <= (u2e + (u2e <<< 1)) - (u3e <<< 1);
            r_h10 <= u3e - (u2e <<< 1) + ue;
            r_h11 <= u3e - u2e;
        end
        if (i_cmd.div_start) begin
            // linear form folds the from value in ahead of the product
            r_acc <= (i_mode == kti_pkg::MODE_HERMITE) ? 64'sd0
                     : ($signed({{32{r_from.value[31]}}, r_from.value}) <<< FRAC_BITS);
        end else if (r_pvld) begin
            case (r_pop)
                kti_pkg::MOP_U2: r_u2 <= r_prod[2*FRAC_BITS-1:FRAC_BITS];
                kti_pkg::MOP_U3: r_u3 <= r_prod[2*FRAC_BITS-1:FRAC_BITS];
                default:         r_acc <= r_acc + prod_ext;
            endcase
        end
    end

    assign sh = r_acc >>> FRAC_BITS;

    always_comb begin
        if (sh > 64'sh0000_0000_7FFF_FFFF) begin
            sat = 32'h7FFF_FFFF;
        end else if (sh < -64'sh0000_0000_8000_0000) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sh[31:0];
        end
    end

    // output register
    logic        r_ovld;
    logic [31:0] r_oval;
    logic        r_ofound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_m_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oval   <= r_found ? sat : 32'd0;
            r_ofound <= r_found;
        end
    end

    assign o_sts.scan_hit  = hit;
    assign o_sts.scan_miss = i_cmd.scan_run
                             && (r_none || (r_rd_vld && r_rd_last && !hit));
    assign o_sts.div_done  = r_dcnt == '0;
    assign o_sts.out_free  = !r_ovld || i_m_ready;
    assign o_m_valid       = r_ovld;
    assign o_sample_value  = r_oval;
    assign o_found         = r_ofound;

endmodule

@@ hdl/keyframe_track_interpolator_top.sv @@
// A key write goes to the table when accepted; a sample first searches the table (keys read
// one a cycle), then runs a restoring division, then the multiply steps (one product for
// linear; u^2, u^3, the weights and four products for Hermite) and loads the output register.
// One sample at a time: no new word is taken until its result is loaded into the output
// register, which waits while the output is stalled; a miss skips division and multiplies.
// Reset (synchronous, active low) clears control state and both registers, not the key table.
module keyframe_track_interpolator_top #(
    parameter int KEYS      = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // key_index, key_time, key_value, key_in_tangent, key_out_tangent, sample_time
    input  logic [167:0] i_s_tdata,
    // command
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sample_value
    output logic [31:0]  o_m_tdata,
    // found
    output logic [0:0]   o_m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic          r_mode;
    logic [6:0]    r_key_count;
    logic          cfg_wr;
    kti_pkg::t_cmd cmd;
    kti_pkg::t_sts sts;
    kti_pkg::t_key key;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kti_pkg::MODE_LINEAR;
            r_key_count <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                kti_pkg::ADDR_MODE:  r_mode      <= pwdata[0];
                kti_pkg::ADDR_COUNT: r_key_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            kti_pkg::ADDR_MODE:  prdata = {31'd0, r_mode};
            kti_pkg::ADDR_COUNT: prdata = {25'd0, r_key_count};
            default:             prdata = 32'd0;
        endcase
    end

    assign key.key_time = i_s_tdata[37:6];
    assign key.value    = i_s_tdata[69:38];
    assign key.in_tan   = i_s_tdata[101:70];
    assign key.out_tan  = i_s_tdata[133:102];

    kti_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_command (i_s_tuser[0]),
        .i_mode    (r_mode),
        .i_sts     (sts),
        .o_s_ready (o_s_tready),
        .o_cmd     (cmd)
    );

    kti_dp #(
        .KEYS      (KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_key_index    (i_s_tdata[5:0]),
        .i_key          (key),
        .i_sample_time  (i_s_tdata[165:134]),
        .i_mode         (r_mode),
        .i_key_count    (r_key_count),
        .i_m_ready      (i_m_tready),
        .o_sts          (sts),
        .o_m_valid      (o_m_tvalid),
        .o_sample_value (o_m_tdata),
        .o_found        (o_m_tuser[0])
    );

endmodule

@@ hdl/kti_checker.sv @@
// Port-level checks for the keyframe track interpolator, bound to the top level.
module kti_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [0:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [31:0]  o_m_tdata,
    input logic [0:0]   o_m_tuser
);

    // a waiting word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("value not zero without a bracket");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered straight after reset");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser[0] == kti_pkg::CMD_WRITE) && !o_m_tvalid
        |=> !o_m_tvalid)
        else $error("key write produced a result");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser[0] == kti_pkg::CMD_SAMPLE)
        |=> !o_s_tready)
        else $error("new word taken during a sample");

endmodule

bind keyframe_track_interpolator_top kti_checker u_kti_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
